@@ hw/rtl/ugsw_pkg.sv @@
// ----------------------------------------------------------------------------
// ugsw_pkg
// Shared types and constants for the uniform grid segment walk block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ugsw_pkg;

    // Field widths
    localparam int COORD_W   = 32;
    localparam int COL_W     = 10;
    localparam int GRID_W    = 10;
    localparam int STEP_W    = 6;
    localparam int CFG_IDX_W = 8;
    localparam int IN_W      = 4 * COORD_W;
    localparam int OUT_W     = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 8'd3;

    // Saturation codes of the fixed divider
    localparam logic [COORD_W-1:0] FIX_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] FIX_MIN = 32'h8000_0000;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIRS,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_MULY,
        ST_ADDY,
        ST_MULX,
        ST_ADDX,
        ST_WALK
    } ugsw_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic dirs;
        logic div_go;
        logic div_sel;      // 0: slope of y per x column, 1: slope of x per y row
        logic store_ystep;
        logic store_xstep;
        logic mul_go;
        logic mul_sel;      // 0: y intercept product, 1: x intercept product
        logic add_y;
        logic add_x;
        logic walk_load;
    } ugsw_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
        logic walk_last;
    } ugsw_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ugsw_div.sv @@
// ----------------------------------------------------------------------------
// ugsw_div
// Saturating signed fixed-point divider, radix 2, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ugsw_div #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic signed [ugsw_pkg::COORD_W-1:0] num,
    input  wire logic [ugsw_pkg::COORD_W-1:0]   den,
    output logic                                done,
    output logic [ugsw_pkg::COORD_W-1:0]        quot
);
    import ugsw_pkg::*;

    localparam int QB    = 2 * FRACTION_BITS;
    localparam int CNT_W = $clog2(QB + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      den_reg, den_next;
    logic [QB-1:0]    dvd_reg, dvd_next;
    logic [QB-1:0]    q_reg, q_next;
    logic             neg_reg, neg_next;
    logic             sat_reg, sat_next;

    logic [31:0] mag;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] q32;

    // Magnitude of the numerator and one restoring trial subtraction
    always_comb
    begin
        mag   = num[31] ? (~num + 32'd1) : num;
        trial = {rem_reg, dvd_reg[QB-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    // Load on start, then iterate one quotient bit a cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QB);
            rem_next  = mag >> FRACTION_BITS;
            den_next  = den;
            dvd_next  = {mag[FRACTION_BITS-1:0], {FRACTION_BITS{1'b0}}};
            q_next    = '0;
            neg_next  = num[31];
            sat_next  = ((mag >> (FRACTION_BITS - 2)) >= den);
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[31:0] : trial[31:0];
            q_next   = {q_reg[QB-2:0], ge};
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        sat_reg <= sat_next;
    end

    // Apply sign or saturation
    always_comb
    begin
        q32 = 32'(q_reg);
        if (sat_reg)
            quot = neg_reg ? FIX_MIN : FIX_MAX;
        else
            quot = neg_reg ? (~q32 + 32'd1) : q32;
    end

    assign done = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ugsw_ctrl.sv @@
// ----------------------------------------------------------------------------
// ugsw_ctrl
// Controller: sequences segment setup, the two slope divisions, the
// intercept products and the block walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ugsw_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire ugsw_pkg::ugsw_stat_t stat,
    output ugsw_pkg::ugsw_cmd_t       cmd
);
    import ugsw_pkg::*;

    ugsw_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_PREP;
            end
            ST_PREP:      state_next = ST_DIRS;
            ST_DIRS:      state_next = ST_DIVY_GO;
            ST_DIVY_GO:   state_next = ST_DIVY_WAIT;
            ST_DIVY_WAIT:
            begin
                if (stat.div_done)
                    state_next = ST_DIVX_GO;
            end
            ST_DIVX_GO:   state_next = ST_DIVX_WAIT;
            ST_DIVX_WAIT:
            begin
                if (stat.div_done)
                    state_next = ST_MULY;
            end
            ST_MULY:      state_next = ST_ADDY;
            ST_ADDY:      state_next = ST_MULX;
            ST_MULX:      state_next = ST_ADDX;
            ST_ADDX:      state_next = ST_WALK;
            ST_WALK:
            begin
                if (stat.out_free && stat.walk_last)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_PREP:      cmd.prep = 1'b1;
            ST_DIRS:      cmd.dirs = 1'b1;
            ST_DIVY_GO:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = 1'b0;
            end
            ST_DIVY_WAIT: cmd.store_ystep = stat.div_done;
            ST_DIVX_GO:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = 1'b1;
            end
            ST_DIVX_WAIT: cmd.store_xstep = stat.div_done;
            ST_MULY:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = 1'b0;
            end
            ST_ADDY:      cmd.add_y = 1'b1;
            ST_MULX:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = 1'b1;
            end
            ST_ADDX:      cmd.add_x = 1'b1;
            ST_WALK:      cmd.walk_load = stat.out_free;
            default:      cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/ugsw_datapath.sv @@
// ----------------------------------------------------------------------------
// ugsw_datapath
// Datapath: configuration registers, segment setup arithmetic, slope divider,
// intercept multiplier, grid walk registers and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ugsw_datapath #(
    parameter int BLOCK_SHIFT   = 23,
    parameter int FRACTION_BITS = 16,
    parameter int MAX_STEPS     = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ugsw_pkg::ugsw_cmd_t             cmd,
    output ugsw_pkg::ugsw_stat_t                 stat,
    input  wire logic [ugsw_pkg::IN_W-1:0]       s_tdata,
    input  wire logic                            cfg_valid,
    input  wire logic [ugsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ugsw_pkg::COORD_W-1:0]    cfg_data,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [ugsw_pkg::OUT_W-1:0]           m_tdata,
    output logic                                 m_tlast
);
    import ugsw_pkg::*;

    localparam int MAP_W = ((32 - BLOCK_SHIFT) > 8 ? (32 - BLOCK_SHIFT) : 8) + 1;
    localparam int BTF   = BLOCK_SHIFT - FRACTION_BITS;
    localparam int P_W   = FRACTION_BITS + 1;
    localparam int PR_W  = P_W + 1 + COORD_W;

    localparam logic [31:0]    FRAC_ONE = 32'd1 << FRACTION_BITS;
    localparam logic [31:0]    NO_STEP  = 32'd256 << FRACTION_BITS;
    localparam logic [P_W-1:0] PART_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    // Configuration registers
    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [GRID_W-1:0]  grid_width_reg, grid_height_reg;

    // Segment registers
    logic signed [31:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [31:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic               xpos_reg, xneg_reg, ypos_reg, yneg_reg;
    logic signed [MAP_W-1:0] xt2_reg, yt2_reg;
    logic [P_W-1:0]     partx_reg, party_reg;
    logic signed [31:0] ystep_reg, xstep_reg;
    logic signed [PR_W-1:0] prod_reg;
    logic signed [31:0] xint_reg, yint_reg;
    logic signed [MAP_W-1:0] mapx_reg, mapy_reg;
    logic [STEP_W-1:0]  count_reg;

    // Output register
    logic               out_valid_reg;
    logic [COL_W-1:0]   out_col_reg, out_row_reg;
    logic               out_inside_reg;
    logic [STEP_W-1:0]  out_step_reg;
    logic               out_last_reg;

    // Setup signals
    logic signed [31:0] diff_sx, diff_sy;
    logic               edge_x, edge_y;
    logic signed [31:0] xt1_full, yt1_full, xt2_full, yt2_full;
    logic signed [MAP_W-1:0] xt1, yt1, xt2, yt2;
    logic [FRACTION_BITS-1:0] fracx, fracy;
    logic               xpos, xneg, ypos, yneg;
    logic signed [31:0] x1_sh, y1_sh;

    // Divider connection
    logic signed [31:0] div_num;
    logic [31:0]        div_den;
    logic [31:0]        abs_dx, abs_dy;
    logic               div_done;
    logic [31:0]        div_quot;

    // Walk signals
    logic [31:0]        mapx32, mapy32;
    logic signed [31:0] xq, yq;
    logic               at_end, walk_last, in_grid, xhit, yhit;
    logic               out_free;

    // Hold configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            grid_width_reg  <= '0;
            grid_height_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GRID_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[GRID_W-1:0];
                default:         ;
            endcase
        end
    end

    // Nudge start points off block edges, move into grid space
    always_comb
    begin
        diff_sx = sx_reg - origin_x_reg;
        diff_sy = sy_reg - origin_y_reg;
        edge_x  = (diff_sx[BLOCK_SHIFT-1:0] == '0);
        edge_y  = (diff_sy[BLOCK_SHIFT-1:0] == '0);
    end

    // Block indexes, step directions and partial block fractions
    always_comb
    begin
        xt1_full = x1_reg >>> BLOCK_SHIFT;
        yt1_full = y1_reg >>> BLOCK_SHIFT;
        xt2_full = x2_reg >>> BLOCK_SHIFT;
        yt2_full = y2_reg >>> BLOCK_SHIFT;
        xt1      = xt1_full[MAP_W-1:0];
        yt1      = yt1_full[MAP_W-1:0];
        xt2      = xt2_full[MAP_W-1:0];
        yt2      = yt2_full[MAP_W-1:0];
        xpos     = (xt2 > xt1);
        xneg     = (xt2 < xt1);
        ypos     = (yt2 > yt1);
        yneg     = (yt2 < yt1);
        fracx    = x1_reg[BLOCK_SHIFT-1:BTF];
        fracy    = y1_reg[BLOCK_SHIFT-1:BTF];
        x1_sh    = x1_reg >>> BTF;
        y1_sh    = y1_reg >>> BTF;
    end

    // Select divider operands
    always_comb
    begin
        abs_dx  = dx_reg[31] ? (~dx_reg + 32'd1) : dx_reg;
        abs_dy  = dy_reg[31] ? (~dy_reg + 32'd1) : dy_reg;
        div_num = cmd.div_sel ? dx_reg : dy_reg;
        div_den = cmd.div_sel ? abs_dy : abs_dx;
    end

    ugsw_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Walk state decode
    always_comb
    begin
        mapx32    = {{(32-MAP_W){mapx_reg[MAP_W-1]}}, mapx_reg};
        mapy32    = {{(32-MAP_W){mapy_reg[MAP_W-1]}}, mapy_reg};
        xq        = xint_reg >>> FRACTION_BITS;
        yq        = yint_reg >>> FRACTION_BITS;
        at_end    = (mapx_reg == xt2_reg) && (mapy_reg == yt2_reg);
        walk_last = at_end || (count_reg == STEP_W'(MAX_STEPS - 1));
        in_grid   = !mapx32[31] && !mapy32[31] &&
                    (mapx32 < {{(32-GRID_W){1'b0}}, grid_width_reg}) &&
                    (mapy32 < {{(32-GRID_W){1'b0}}, grid_height_reg});
        yhit      = (yq == $signed(mapy32));
        xhit      = (xq == $signed(mapx32));
        out_free  = !out_valid_reg || m_tready;
    end

    // Segment setup and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sx_reg <= s_tdata[31:0];
            sy_reg <= s_tdata[63:32];
            ex_reg <= s_tdata[95:64];
            ey_reg <= s_tdata[127:96];
        end
        if (cmd.prep)
        begin
            x1_reg <= diff_sx + (edge_x ? FRAC_ONE : 32'd0);
            y1_reg <= diff_sy + (edge_y ? FRAC_ONE : 32'd0);
            x2_reg <= ex_reg - origin_x_reg;
            y2_reg <= ey_reg - origin_y_reg;
        end
        if (cmd.dirs)
        begin
            dx_reg    <= x2_reg - x1_reg;
            dy_reg    <= y2_reg - y1_reg;
            xpos_reg  <= xpos;
            xneg_reg  <= xneg;
            ypos_reg  <= ypos;
            yneg_reg  <= yneg;
            xt2_reg   <= xt2;
            yt2_reg   <= yt2;
            mapx_reg  <= xt1;
            mapy_reg  <= yt1;
            count_reg <= '0;
            partx_reg <= xpos ? (PART_ONE - {1'b0, fracx}) :
                         xneg ? {1'b0, fracx} : PART_ONE;
            party_reg <= ypos ? (PART_ONE - {1'b0, fracy}) :
                         yneg ? {1'b0, fracy} : PART_ONE;
        end
        if (cmd.store_ystep)
            ystep_reg <= (xpos_reg || xneg_reg) ? div_quot : NO_STEP;
        if (cmd.store_xstep)
            xstep_reg <= (ypos_reg || yneg_reg) ? div_quot : NO_STEP;
        if (cmd.mul_go)
        begin
            if (cmd.mul_sel)
                prod_reg <= $signed({1'b0, party_reg}) * xstep_reg;
            else
                prod_reg <= $signed({1'b0, partx_reg}) * ystep_reg;
        end
        if (cmd.add_y)
            yint_reg <= y1_sh + prod_reg[FRACTION_BITS+31:FRACTION_BITS];
        if (cmd.add_x)
            xint_reg <= x1_sh + prod_reg[FRACTION_BITS+31:FRACTION_BITS];
        // Advance one block per emitted result
        if (cmd.walk_load)
        begin
            count_reg <= count_reg + STEP_W'(1);
            if (yhit)
            begin
                yint_reg <= yint_reg + ystep_reg;
                if (xpos_reg)
                    mapx_reg <= mapx_reg + MAP_W'(1);
                else if (xneg_reg)
                    mapx_reg <= mapx_reg - MAP_W'(1);
            end
            else if (xhit)
            begin
                xint_reg <= xint_reg + xstep_reg;
                if (ypos_reg)
                    mapy_reg <= mapy_reg + MAP_W'(1);
                else if (yneg_reg)
                    mapy_reg <= mapy_reg - MAP_W'(1);
            end
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.walk_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.walk_load)
        begin
            out_col_reg    <= mapx32[COL_W-1:0];
            out_row_reg    <= mapy32[COL_W-1:0];
            out_inside_reg <= in_grid;
            out_step_reg   <= count_reg;
            out_last_reg   <= walk_last;
        end
    end

    assign stat.div_done  = div_done;
    assign stat.out_free  = out_free;
    assign stat.walk_last = walk_last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_step_reg, out_inside_reg, out_row_reg, out_col_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/uniform_grid_segment_walk_top.sv @@
// ----------------------------------------------------------------------------
// uniform_grid_segment_walk_top
// Fixed-point grid DDA: walks a segment across a uniform block grid and
// emits every visited block in order.
// ----------------------------------------------------------------------------
//  Channel  Dir  Transaction                Payload
//  s_*      in   one segment                start_x, start_y, end_x, end_y
//  m_*      out  one visited block          col, row, inside_map, step; tlast
//  cfg_*    in   one register write         cfg_index, cfg_data
//
//  After a segment is accepted, the radix-2 divider runs twice, once per
//  slope, before the first block reaches the output register. The walk then
//  emits one block per cycle while m_tready is high, up to MAX_STEPS blocks.
//  A new segment is taken once the last block sits in the output register.
//  Reset is asynchronous, active low; configuration registers reset to zero.
//  A stall on m_tready holds the walk; cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uniform_grid_segment_walk_top #(
    parameter int BLOCK_SHIFT   = 23,
    parameter int FRACTION_BITS = 16,
    parameter int MAX_STEPS     = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // start_x[31:0], start_y[63:32], end_x[95:64], end_y[127:96]
    input  wire logic [ugsw_pkg::IN_W-1:0]       s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // block_col[9:0], block_row[19:10], inside_map[20], step_number[26:21], zero fill
    output logic [ugsw_pkg::OUT_W-1:0]           m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ugsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ugsw_pkg::COORD_W-1:0]    cfg_data
);
    import ugsw_pkg::*;

    ugsw_cmd_t  cmd;
    ugsw_stat_t stat;

    assign cfg_ready = 1'b1;

    // Controller
    ugsw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    ugsw_datapath #(
        .BLOCK_SHIFT   (BLOCK_SHIFT),
        .FRACTION_BITS (FRACTION_BITS),
        .MAX_STEPS     (MAX_STEPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
